// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/uer_pkg.sv -----
// ---------------------------------------------------------------------------
// uer_pkg
// Constants, register indexes and the count-to-distance function of the
// ultrasonic echo ranger.
// ---------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    localparam int CFG_W      = 6;
    localparam int CFG_ADDR_W = 1;
    localparam int DIST_W     = 9;
    localparam int COUNT_W    = 6;

    localparam logic [CFG_W-1:0]   RESET_ECHO_LIMIT   = 6'd25;
    localparam logic [CFG_W-1:0]   RESET_READ_TIMEOUT = 6'd30;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 6'd63;
    localparam logic [DIST_W-1:0]  MAX_CM             = 9'd400;
    localparam logic [DIST_W-1:0]  MIN_CM             = 9'd2;
    localparam logic [DIST_W-1:0]  ONE_TICK_CM        = 9'd17;
    localparam logic [14:0]        SOUND_NUM          = 15'd343;
    // floor(q / 5) == (q * RECIP_5) >> 18 for every q below 2**18
    localparam logic [28:0]        RECIP_5            = 29'd52429;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ECHO_LIMIT   = 1'b0,
        CFG_READ_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        STATUS_OK      = 1'b0,
        STATUS_TIMEOUT = 1'b1
    } status_t;

    // count * 343 / 20, clamped to 2..400, floor of 17 for a single tick
    function automatic logic [DIST_W-1:0] range_from_count(input logic [COUNT_W-1:0] n);
        logic [14:0] prod;
        logic [12:0] quarter;
        logic [28:0] scaled;
        logic [10:0] d;
        logic [DIST_W-1:0] r;
        prod    = 15'(n) * SOUND_NUM;
        quarter = prod[14:2];
        scaled  = 29'(quarter) * RECIP_5;
        d       = scaled[28:18];
        if (d < 11'(MIN_CM))
            r = MIN_CM;
        else if (d > 11'(MAX_CM))
            r = MAX_CM;
        else
            r = d[DIST_W-1:0];
        if (r < ONE_TICK_CM && n == 6'd1)
            r = ONE_TICK_CM;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ultrasonic_echo_ranger.sv -----
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo pulse-width range measurement with armed read and timeout.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one transaction per tick or trigger. s_tuser = 1 is a
//   trigger (start), s_tuser = 0 is a tick with the echo level in s_tdata[0].
//   Master stream m_*: at most one result per input transaction, carrying
//   the distance and counted ticks in m_tdata and the status in m_tuser.
//   Config port: cfg_we/cfg_addr/cfg_wdata, write only while idle.
//   An input taken into the input register is evaluated against the
//   measurement state, and its result is registered and presented on m_*.
//   Throughput: one input per cycle while the receiver does not stall, set by
//   the single state-update step between the input and result registers.
//   Reset clears all measurement state and loads echo_limit = 25 and
//   read_timeout = 30. When the receiver stalls, the result is held and the
//   input register still fills, so at most one more input is taken before
//   s_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,   // [0] echo_level
    input  wire logic                          s_tuser,   // [0] kind
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [15:0]                   m_tdata,   // [8:0] distance_cm, [14:9] echo_ticks
    output      logic                          m_tuser,   // [0] status
    input  wire logic                          cfg_we,
    input  wire logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [uer_pkg::CFG_W-1:0]     cfg_wdata
);
    import uer_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    logic                 in_kind_reg;
    logic                 in_level_reg;

    logic [CFG_W-1:0]     echo_limit_reg, echo_limit_next;
    logic [CFG_W-1:0]     read_timeout_reg, read_timeout_next;

    logic                 prev_echo_reg, prev_echo_next;
    logic                 measuring_reg, measuring_next;
    logic                 done_flag_reg, done_flag_next;
    logic [COUNT_W-1:0]   high_count_reg, high_count_next;
    logic [DIST_W-1:0]    distance_reg, distance_next;
    logic                 read_armed_reg, read_armed_next;
    logic [COUNT_W-1:0]   wait_elapsed_reg, wait_elapsed_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]    out_distance_reg, out_distance_next;
    logic                 out_status_reg, out_status_next;
    logic [COUNT_W-1:0]   out_ticks_reg, out_ticks_next;

    logic                 advance;
    logic                 fire;
    logic                 res_valid;
    logic [DIST_W-1:0]    res_distance;
    logic                 res_status;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ticks_reg, out_distance_reg};
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        echo_limit_next   = echo_limit_reg;
        read_timeout_next = read_timeout_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_ECHO_LIMIT:   echo_limit_next   = cfg_wdata;
                CFG_READ_TIMEOUT: read_timeout_next = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    end

    always_comb
    begin
        prev_echo_next    = prev_echo_reg;
        measuring_next    = measuring_reg;
        done_flag_next    = done_flag_reg;
        high_count_next   = high_count_reg;
        distance_next     = distance_reg;
        read_armed_next   = read_armed_reg;
        wait_elapsed_next = wait_elapsed_reg;
        res_valid         = 1'b0;
        res_distance      = '0;
        res_status        = STATUS_OK;

        if (in_kind_reg)
        begin
            measuring_next    = 1'b0;
            done_flag_next    = 1'b0;
            high_count_next   = '0;
            distance_next     = '0;
            read_armed_next   = 1'b1;
            wait_elapsed_next = '0;
        end
        else
        begin
            if (in_level_reg && !prev_echo_reg)
            begin
                measuring_next  = 1'b1;
                high_count_next = '0;
                done_flag_next  = 1'b0;
            end
            else if (!in_level_reg && prev_echo_reg)
            begin
                measuring_next = 1'b0;
                done_flag_next = 1'b1;
                distance_next  = range_from_count(high_count_reg);
            end

            if (measuring_next && in_level_reg)
            begin
                if (high_count_next < COUNT_MAX)
                    high_count_next = high_count_next + 6'd1;
                if (high_count_next > echo_limit_reg || high_count_next == COUNT_MAX)
                begin
                    measuring_next = 1'b0;
                    done_flag_next = 1'b1;
                    distance_next  = MAX_CM;
                end
            end

            prev_echo_next = in_level_reg;

            if (read_armed_reg)
            begin
                if (done_flag_next)
                begin
                    done_flag_next  = 1'b0;
                    read_armed_next = 1'b0;
                    res_valid       = 1'b1;
                    res_distance    = distance_next;
                    res_status      = STATUS_OK;
                end
                else
                begin
                    if (wait_elapsed_reg < COUNT_MAX)
                        wait_elapsed_next = wait_elapsed_reg + 6'd1;
                    if (wait_elapsed_next >= read_timeout_reg)
                    begin
                        distance_next   = '0;
                        read_armed_next = 1'b0;
                        res_valid       = 1'b1;
                        res_distance    = '0;
                        res_status      = STATUS_TIMEOUT;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_distance_next = out_distance_reg;
        out_status_next   = out_status_reg;
        out_ticks_next    = out_ticks_reg;
        if (advance)
        begin
            out_valid_next    = fire && res_valid;
            out_distance_next = res_distance;
            out_status_next   = res_status;
            out_ticks_next    = high_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            echo_limit_reg   <= RESET_ECHO_LIMIT;
            read_timeout_reg <= RESET_READ_TIMEOUT;
            prev_echo_reg    <= 1'b0;
            measuring_reg    <= 1'b0;
            done_flag_reg    <= 1'b0;
            high_count_reg   <= '0;
            distance_reg     <= '0;
            read_armed_reg   <= 1'b0;
            wait_elapsed_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            echo_limit_reg   <= echo_limit_next;
            read_timeout_reg <= read_timeout_next;
            out_valid_reg    <= out_valid_next;
            if (fire)
            begin
                prev_echo_reg    <= prev_echo_next;
                measuring_reg    <= measuring_next;
                done_flag_reg    <= done_flag_next;
                high_count_reg   <= high_count_next;
                distance_reg     <= distance_next;
                read_armed_reg   <= read_armed_next;
                wait_elapsed_reg <= wait_elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg  <= s_tuser;
            in_level_reg <= s_tdata[0];
        end
        out_distance_reg <= out_distance_next;
        out_status_reg   <= out_status_next;
        out_ticks_reg    <= out_ticks_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_dist_in_range, clk, rst_n, 1'b1, distance_reg <= MAX_CM)
    `ASSERT_IMPLIES(a_timeout_zero, clk, rst_n, out_valid_reg && out_status_reg == STATUS_TIMEOUT, out_distance_reg == '0)
    `ASSERT_IMPLIES(a_success_range, clk, rst_n, out_valid_reg && out_status_reg == STATUS_OK, out_distance_reg >= MIN_CM && out_distance_reg <= MAX_CM)
    `ASSERT_NEXT(a_result_disarms, clk, rst_n, fire && res_valid, !read_armed_reg)

endmodule

`default_nettype wire
